[sv/efma_pkg.sv]
// ----------------------------------------------------------------------------
// efma_pkg: shared constants, types and helpers
// Field prime, coefficient width, pipeline bundles for the multiply-accumulate.
// ----------------------------------------------------------------------------
package efma_pkg;

  localparam int unsigned DEGREE    = 4;
  localparam int unsigned COEF_W    = 50;
  localparam logic [COEF_W-1:0] FIELD_P = 50'd562949954961409;
  localparam logic [2:0]        WRAP_K  = 3'd5;

  typedef logic [COEF_W-1:0] coef_t;
  typedef coef_t [DEGREE-1:0] elem_t;

  // Conditional subtract of p for a value below 2p
  function automatic coef_t red_once(input logic [COEF_W:0] v);
    logic [COEF_W:0] d;
    d = v - {1'b0, FIELD_P};
    red_once = (v >= {1'b0, FIELD_P}) ? d[COEF_W-1:0] : v[COEF_W-1:0];
  endfunction

  // Modular add of two reduced values
  function automatic coef_t add_mod(input coef_t x, input coef_t y);
    add_mod = red_once({1'b0, x} + {1'b0, y});
  endfunction

endpackage

[sv/ext_field_mul_acc.sv]
// ----------------------------------------------------------------------------
// ext_field_mul_acc: multiply-accumulate in GF(p)[x]/(x^4 - 5)
// Returns acc + a*b, every coefficient reduced mod p = 562949954961409.
// ----------------------------------------------------------------------------
// One item is accepted per cycle while the pipeline is not stalled; each result
// passes through one input register, nine multiplier stages and both merge levels
// before it becomes valid. The sixteen coefficient products run in sixteen
// pipelined modular multiplier lanes, whose nine-stage multiply and fold
// reduction makes up most of that path. The whole pipeline advances only when
// its last stage is empty or being drained, so a stalled output holds every
// item in place without loss.
module ext_field_mul_acc (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  efma_pkg::coef_t in_a_c0, in_a_c1, in_a_c2, in_a_c3,
  input  efma_pkg::coef_t in_b_c0, in_b_c1, in_b_c2, in_b_c3,
  input  efma_pkg::coef_t in_acc_c0, in_acc_c1, in_acc_c2, in_acc_c3,
  output logic            out_valid,
  input  logic            out_ready,
  output efma_pkg::coef_t out_sum_c0, out_sum_c1, out_sum_c2, out_sum_c3
);

  localparam int unsigned LAT = 12;

  logic en;
  logic [LAT-1:0] vld_r;
  assign en        = !vld_r[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[LAT-1];

  // Advance the valid line with the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // Reduce raw inputs once and register
  efma_pkg::elem_t a_r, b_r, acc_r;
  always_ff @(posedge clk) begin
    if (en) begin
      a_r   <= {efma_pkg::red_once({1'b0, in_a_c3}), efma_pkg::red_once({1'b0, in_a_c2}),
                efma_pkg::red_once({1'b0, in_a_c1}), efma_pkg::red_once({1'b0, in_a_c0})};
      b_r   <= {efma_pkg::red_once({1'b0, in_b_c3}), efma_pkg::red_once({1'b0, in_b_c2}),
                efma_pkg::red_once({1'b0, in_b_c1}), efma_pkg::red_once({1'b0, in_b_c0})};
      acc_r <= {efma_pkg::red_once({1'b0, in_acc_c3}), efma_pkg::red_once({1'b0, in_acc_c2}),
                efma_pkg::red_once({1'b0, in_acc_c1}), efma_pkg::red_once({1'b0, in_acc_c0})};
    end
  end

  // Delay the accumulator alongside the multipliers
  efma_pkg::elem_t acc_d_r [9];
  always_ff @(posedge clk) begin
    if (en) begin
      acc_d_r[0] <= acc_r;
      for (int s = 1; s < 9; s++) acc_d_r[s] <= acc_d_r[s-1];
    end
  end

  // Sixteen multiplier lanes, grouped by target coefficient
  efma_pkg::coef_t prod [efma_pkg::DEGREE][efma_pkg::DEGREE];
  for (genvar i = 0; i < efma_pkg::DEGREE; i++) begin : g_i
    for (genvar j = 0; j < efma_pkg::DEGREE; j++) begin : g_j
      localparam int K = (i + j) % efma_pkg::DEGREE;
      localparam logic [2:0] KF = (i + j >= efma_pkg::DEGREE) ? efma_pkg::WRAP_K : 3'd1;
      efma_mulmod u_mul (
        .clk (clk),
        .en  (en),
        .x   (a_r[i]),
        .y   (b_r[j]),
        .k   (KF),
        .z   (prod[K][i])
      );
    end
  end

  efma_pkg::elem_t sum;
  efma_merge u_merge (
    .clk  (clk),
    .en   (en),
    .acc  (acc_d_r[8]),
    .prod (prod),
    .sum  (sum)
  );

  assign out_sum_c0 = sum[0];
  assign out_sum_c1 = sum[1];
  assign out_sum_c2 = sum[2];
  assign out_sum_c3 = sum[3];

  // Stalled output holds valid and coefficients 0 and 3, results stay reduced, nothing appears from nothing
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sum_c0) && $stable(out_sum_c3))
    else $error("result moved while stalled");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sum_c0 < efma_pkg::FIELD_P && out_sum_c1 < efma_pkg::FIELD_P
                  && out_sum_c2 < efma_pkg::FIELD_P && out_sum_c3 < efma_pkg::FIELD_P)
    else $error("result not reduced");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r == '0 && !(in_valid && in_ready) |=> !out_valid)
    else $error("result without item");

endmodule

[sv/efma_mulmod.sv]
// ----------------------------------------------------------------------------
// efma_mulmod: pipelined modular multiplier
// Four 25x25 partial products, then reduction of the 100-bit product mod p
// using p = 2^49 + c with c = 2^20 + 2^19 - 2^15 + 1, folded over registered
// stages. The stages advance together on en, with no stalls inside.
// ----------------------------------------------------------------------------
module efma_mulmod (
  input  logic            clk,
  input  logic            en,
  input  efma_pkg::coef_t x,
  input  efma_pkg::coef_t y,
  input  logic [2:0]      k,
  output efma_pkg::coef_t z
);

  // Stage 1: partial products
  logic [49:0] pll_r, plh_r, phl_r, phh_r;
  logic [2:0]  k1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      pll_r <= 50'(x[24:0]  * y[24:0]);
      plh_r <= 50'(x[24:0]  * y[49:25]);
      phl_r <= 50'(x[49:25] * y[24:0]);
      phh_r <= 50'(x[49:25] * y[49:25]);
      k1_r  <= k;
    end
  end

  // Stage 2: assemble full product
  logic [99:0] prod_r;
  logic [2:0]  k2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= {50'd0, pll_r} + ({50'd0, plh_r} << 25) + ({50'd0, phl_r} << 25)
              + ({50'd0, phh_r} << 50);
      k2_r   <= k1_r;
    end
  end

  // Fold: 2^49 = -c mod p. value = L + H*2^49 -> L - H*c, with H*c formed as
  // (H<<20) + (H<<19) - (H<<15) + H. Add a multiple of p to stay non-negative.
  // Stage 3: product < 2^99, H < 2^51, H*c < 2^72; add 2^23*p.
  localparam logic [95:0] OFF1  = {46'd0, efma_pkg::FIELD_P} << 23;
  localparam logic [95:0] OFF_P = {46'd0, efma_pkg::FIELD_P};
  logic [95:0] h1;
  logic [95:0] f1_r;
  logic [2:0]  k3_r;
  assign h1 = {45'd0, prod_r[99:49]};
  always_ff @(posedge clk) begin
    if (en) begin
      f1_r <= {47'd0, prod_r[48:0]} + OFF1
            - (h1 << 20) - (h1 << 19) + (h1 << 15) - h1;
      k3_r <= k2_r;
    end
  end

  // Stage 4: second fold, f1 < 2^73: H < 2^24, H*c < 2^45 < p; add p.
  // Result is below 2^49 + p from here on.
  logic [95:0] h2;
  logic [95:0] f2_r;
  logic [2:0]  k4_r;
  assign h2 = {49'd0, f1_r[95:49]};
  always_ff @(posedge clk) begin
    if (en) begin
      f2_r <= {47'd0, f1_r[48:0]} + OFF_P
            - (h2 << 20) - (h2 << 19) + (h2 << 15) - h2;
      k4_r <= k3_r;
    end
  end

  // Stage 5: fold again, H < 4; the bound 2^49 + p holds
  logic [95:0] h3;
  logic [95:0] f3_r;
  logic [2:0]  k5_r;
  assign h3 = {49'd0, f2_r[95:49]};
  always_ff @(posedge clk) begin
    if (en) begin
      f3_r <= {47'd0, f2_r[48:0]} + OFF_P
            - (h3 << 20) - (h3 << 19) + (h3 << 15) - h3;
      k5_r <= k4_r;
    end
  end

  // Stage 6: fold again, H < 4
  logic [95:0] h4;
  logic [95:0] f4_r;
  logic [2:0]  k6_r;
  assign h4 = {49'd0, f3_r[95:49]};
  always_ff @(posedge clk) begin
    if (en) begin
      f4_r <= {47'd0, f3_r[48:0]} + OFF_P
            - (h4 << 20) - (h4 << 19) + (h4 << 15) - h4;
      k6_r <= k5_r;
    end
  end

  // Stage 7: fold again, H < 4
  logic [95:0] h5;
  logic [95:0] f5_r;
  logic [2:0]  k7_r;
  assign h5 = {49'd0, f4_r[95:49]};
  always_ff @(posedge clk) begin
    if (en) begin
      f5_r <= {47'd0, f4_r[48:0]} + OFF_P
            - (h5 << 20) - (h5 << 19) + (h5 << 15) - h5;
      k7_r <= k6_r;
    end
  end

  // Stage 8: f5 < 2^49 + p: subtract multiple of p by compare ladder,
  // then apply wrap factor (1 or 5) as shift-add.
  logic [52:0] r1;
  logic [49:0] rr;
  always_comb begin
    r1 = f5_r[52:0];
    if (r1 >= 53'({efma_pkg::FIELD_P, 2'b00})) r1 = r1 - 53'({efma_pkg::FIELD_P, 2'b00});
    if (r1 >= 53'({efma_pkg::FIELD_P, 1'b0}))  r1 = r1 - 53'({efma_pkg::FIELD_P, 1'b0});
    if (r1 >= 53'(efma_pkg::FIELD_P))          r1 = r1 - 53'(efma_pkg::FIELD_P);
    rr = r1[49:0];
  end

  logic [52:0] m_r;
  always_ff @(posedge clk) begin
    if (en) begin
      m_r <= (k7_r == efma_pkg::WRAP_K) ? ({3'd0, rr} << 2) + {3'd0, rr} : {3'd0, rr};
    end
  end

  // Stage 9: final reduction, m < 5p
  logic [52:0] r2;
  always_comb begin
    r2 = m_r;
    if (r2 >= 53'({efma_pkg::FIELD_P, 2'b00})) r2 = r2 - 53'({efma_pkg::FIELD_P, 2'b00});
    if (r2 >= 53'({efma_pkg::FIELD_P, 1'b0}))  r2 = r2 - 53'({efma_pkg::FIELD_P, 1'b0});
    if (r2 >= 53'(efma_pkg::FIELD_P))          r2 = r2 - 53'(efma_pkg::FIELD_P);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z <= r2[49:0];
    end
  end

endmodule

[sv/efma_merge.sv]
// ----------------------------------------------------------------------------
// efma_merge: merging stage
// Adds the lane products into each accumulator coefficient, two levels.
// ----------------------------------------------------------------------------
module efma_merge (
  input  logic            clk,
  input  logic            en,
  input  efma_pkg::elem_t acc,
  input  efma_pkg::coef_t prod [efma_pkg::DEGREE][efma_pkg::DEGREE],
  output efma_pkg::elem_t sum
);

  // prod[k][i]: term a_i*b_j that lands in coefficient k
  efma_pkg::coef_t lvl_r [efma_pkg::DEGREE][3];

  // Level one: pairwise sums, with the accumulator registered alongside
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < efma_pkg::DEGREE; k++) begin
        lvl_r[k][0] <= efma_pkg::add_mod(prod[k][0], prod[k][1]);
        lvl_r[k][1] <= efma_pkg::add_mod(prod[k][2], prod[k][3]);
        lvl_r[k][2] <= acc[k];
      end
    end
  end

  // Level two: fold the three partial sums
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < efma_pkg::DEGREE; k++) begin
        sum[k] <= efma_pkg::add_mod(efma_pkg::add_mod(lvl_r[k][0], lvl_r[k][1]),
                                    lvl_r[k][2]);
      end
    end
  end

endmodule

[dv/ext_field_mul_acc_tb.sv]
// ----------------------------------------------------------------------------
// ext_field_mul_acc_tb: self-checking bench for the extension field MAC
// Drives directed rows then random items with random gaps on both channels,
// predicts acc + a*b in GF(p)[x]/(x^4 - 5) and checks each result in order.
// ----------------------------------------------------------------------------
module ext_field_mul_acc_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM  = 1000;
  localparam int WDOG_MAX  = 20000;
  localparam int DRAIN_CYC = 40;
  localparam efma_pkg::coef_t MAX_C = {efma_pkg::COEF_W{1'b1}};
  localparam efma_pkg::coef_t PM1   = efma_pkg::FIELD_P - 1;

  typedef struct packed {
    efma_pkg::elem_t a;
    efma_pkg::elem_t b;
    efma_pkg::elem_t acc;
  } mac_item_t;

  typedef struct {
    mac_item_t       item;
    logic            has_sum;
    efma_pkg::elem_t sum;
  } dir_row_t;

  logic  clk, rst_n;
  logic  in_valid, in_ready, out_valid, out_ready;
  efma_pkg::elem_t in_a, in_b, in_acc, out_sum;

  efma_pkg::elem_t sum_queue[$];
  dir_row_t  dir_rows[$];
  int        n_mismatch;
  int        idle_cycles;
  bit        timed_out;
  bit        stim_done;

  ext_field_mul_acc i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_a_c0(in_a[0]), .in_a_c1(in_a[1]), .in_a_c2(in_a[2]), .in_a_c3(in_a[3]),
    .in_b_c0(in_b[0]), .in_b_c1(in_b[1]), .in_b_c2(in_b[2]), .in_b_c3(in_b[3]),
    .in_acc_c0(in_acc[0]), .in_acc_c1(in_acc[1]),
    .in_acc_c2(in_acc[2]), .in_acc_c3(in_acc[3]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_sum_c0(out_sum[0]), .out_sum_c1(out_sum[1]),
    .out_sum_c2(out_sum[2]), .out_sum_c3(out_sum[3])
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // Fold one 50-bit value into [0, p)
  function automatic logic [63:0] fold_coef(input efma_pkg::coef_t v);
    fold_coef = (v >= efma_pkg::FIELD_P) ? 64'(v) - 64'(efma_pkg::FIELD_P) : 64'(v);
  endfunction

  // Exact product mod p through a 128-bit intermediate
  function automatic logic [63:0] prod_mod(input logic [63:0] x, input logic [63:0] y);
    logic [127:0] t;
    t = 128'(x) * 128'(y);
    prod_mod = 64'(t % 128'(efma_pkg::FIELD_P));
  endfunction

  function automatic efma_pkg::elem_t predict_mac(input mac_item_t it);
    logic [63:0] a[efma_pkg::DEGREE], b[efma_pkg::DEGREE], s[efma_pkg::DEGREE], t;
    int k;
    efma_pkg::elem_t r;
    for (int i = 0; i < efma_pkg::DEGREE; i++) begin
      a[i] = fold_coef(it.a[i]);
      b[i] = fold_coef(it.b[i]);
      s[i] = fold_coef(it.acc[i]);
    end
    for (int i = 0; i < efma_pkg::DEGREE; i++)
      for (int j = 0; j < efma_pkg::DEGREE; j++) begin
        t = prod_mod(a[i], b[j]);
        k = i + j;
        if (k >= efma_pkg::DEGREE) begin
          t = prod_mod(t, 64'(efma_pkg::WRAP_K));
          k -= efma_pkg::DEGREE;
        end
        s[k] = (s[k] + t) % 64'(efma_pkg::FIELD_P);
      end
    for (int i = 0; i < efma_pkg::DEGREE; i++) r[i] = s[i][efma_pkg::COEF_W-1:0];
    return r;
  endfunction

  function automatic efma_pkg::coef_t rand_coef();
    efma_pkg::coef_t v;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = PM1;
      2: v = efma_pkg::FIELD_P + efma_pkg::coef_t'($urandom_range(0, 1000));
      3: v = MAX_C - efma_pkg::coef_t'($urandom_range(0, 3));
      4: v = efma_pkg::coef_t'($urandom_range(0, 15));
      default: v = efma_pkg::coef_t'({$urandom, $urandom});
    endcase
    return v;
  endfunction

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic mac_item_t fill_item(input efma_pkg::coef_t va, input efma_pkg::coef_t vb,
                                          input efma_pkg::coef_t vc);
    mac_item_t it;
    for (int i = 0; i < efma_pkg::DEGREE; i++) begin
      it.a[i] = va; it.b[i] = vb; it.acc[i] = vc;
    end
    return it;
  endfunction

  task automatic add_row(input mac_item_t it, input logic has, input efma_pkg::elem_t s);
    dir_row_t r;
    r.item = it; r.has_sum = has; r.sum = s;
    dir_rows.push_back(r);
  endtask

  // Present one item and hold it until accepted
  task automatic send_item(input mac_item_t it, input efma_pkg::elem_t expd);
    in_a = it.a; in_b = it.b; in_acc = it.acc;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    sum_queue.push_back(expd);
    @(negedge clk);
  endtask

  task automatic build_rows();
    mac_item_t it;
    efma_pkg::elem_t z, s;
    z = '0;
    add_row(fill_item(0, 0, 0), 1'b1, z);
    // zero product leaves the accumulator, folded
    add_row(fill_item(0, PM1, PM1), 1'b1, {efma_pkg::DEGREE{PM1}});
    add_row(fill_item(PM1, 0, efma_pkg::FIELD_P), 1'b1, z);
    add_row(fill_item(0, 0, MAX_C), 1'b1, {efma_pkg::DEGREE{MAX_C - efma_pkg::FIELD_P}});
    // unit times unit: one at x^0 only
    it = '0; it.a[0] = 1; it.b[0] = 1;
    s = '0; s[0] = 1;
    add_row(it, 1'b1, s);
    // x^1 * x^3 wraps to 5
    it = '0; it.a[1] = 1; it.b[3] = 1;
    s = '0; s[0] = 5;
    add_row(it, 1'b1, s);
    it = '0; it.a[2] = efma_pkg::FIELD_P + 1; it.b[2] = 1;
    s = '0; s[0] = 5;
    add_row(it, 1'b1, s);
    add_row(fill_item(PM1, PM1, PM1), 1'b0, z);
    add_row(fill_item(MAX_C, MAX_C, MAX_C), 1'b0, z);
    add_row(fill_item(efma_pkg::FIELD_P, MAX_C, 0), 1'b0, z);
    add_row(fill_item(MAX_C, 1, 0), 1'b0, z);
    for (int i = 0; i < 8; i++) begin
      for (int k = 0; k < efma_pkg::DEGREE; k++) begin
        it.a[k] = rand_coef(); it.b[k] = rand_coef(); it.acc[k] = rand_coef();
      end
      add_row(it, 1'b0, z);
    end
  endtask

  // Stimulus
  initial begin
    mac_item_t it;
    dir_row_t  r;
    int        gap;
    in_valid = 1'b0; in_a = '0; in_b = '0; in_acc = '0;
    rst_n = 1'b0; stim_done = 1'b0;
    build_rows();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    foreach (dir_rows[n]) begin
      r = dir_rows[n];
      send_item(r.item, r.has_sum ? r.sum : predict_mac(r.item));
    end
    in_valid = 1'b0;
    for (int n = 0; n < N_RANDOM; n++) begin
      // hold off until the pipeline has drained
      if (n == N_RANDOM / 2) begin
        in_valid = 1'b0;
        while (sum_queue.size() != 0) @(negedge clk);
      end
      gap = (n >= 100 && n < 200) ? 0 : rand_gap();
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      for (int k = 0; k < efma_pkg::DEGREE; k++) begin
        it.a[k] = rand_coef(); it.b[k] = rand_coef(); it.acc[k] = rand_coef();
      end
      send_item(it, predict_mac(it));
    end
    in_valid = 1'b0;
    stim_done = 1'b1;
  end

  // Result side: random back-pressure
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = ($urandom_range(0, 9) < 3) ? rand_gap() : 0;
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Check each accepted result against the oldest prediction
  always @(posedge clk) begin
    efma_pkg::elem_t expd;
    if (rst_n && out_valid && out_ready) begin
      if (sum_queue.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result %h", out_sum);
      end else begin
        expd = sum_queue.pop_front();
        for (int i = 0; i < efma_pkg::DEGREE; i++)
          if (out_sum[i] !== expd[i]) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("sum_c%0d mismatch: expected %h actual %h", i, expd[i], out_sum[i]);
          end
      end
    end
  end

  // Watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    timed_out = 1'b0;
    fork
      begin
        wait (stim_done && sum_queue.size() == 0);
        repeat (DRAIN_CYC) @(posedge clk);
      end
      begin
        wait (idle_cycles >= WDOG_MAX);
        timed_out = 1'b1;
      end
    join_any
    if (timed_out || n_mismatch != 0 || sum_queue.size() != 0) $display("status: fail");
    else $display("status: pass");
    $finish;
  end

endmodule
